### rtl/core/naf_pkg.sv
// ----------------------------------------------------------------------------
// naf_pkg
// Shared widths, register codes, divider constants and structs for the
// 3x3 neighbourhood mean filter.
// ----------------------------------------------------------------------------
package naf_pkg;

   // image geometry
   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 4096;
   localparam int COL_W      = $clog2(MAX_WIDTH);       // column index
   localparam int WID_W      = COL_W + 1;               // holds MAX_WIDTH itself
   localparam int ROW_W      = $clog2(MAX_HEIGHT) + 1;  // holds height + 1

   // pixel and arithmetic widths
   localparam int PIX_W  = 8;
   localparam int LINE_W = 2 * PIX_W;                   // {upper, middle}
   localparam int SUM_W  = PIX_W + 3;                   // up to 8 neighbours
   localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

   // register file
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int WREG_W     = 9;
   localparam int HREG_W     = 13;
   typedef logic [1:0] reg_index_type;
   localparam reg_index_type REG_IMAGE_WIDTH   = 2'd0;
   localparam reg_index_type REG_IMAGE_HEIGHT  = 2'd1;
   localparam reg_index_type REG_FILTER_ENABLE = 2'd2;
   localparam logic [WREG_W-1:0] RST_IMAGE_WIDTH  = 9'd256;
   localparam logic [HREG_W-1:0] RST_IMAGE_HEIGHT = 13'd256;
   localparam logic              RST_FILTER_EN    = 1'b1;

   // neighbour count divider: multiply by reciprocal, shift right
   typedef logic [1:0] div_sel_type;
   localparam div_sel_type DIV_BY3 = 2'd0;   // corner
   localparam div_sel_type DIV_BY5 = 2'd1;   // edge
   localparam div_sel_type DIV_BY8 = 2'd2;   // interior
   localparam int RECIP_SHIFT = 13;
   localparam int RECIP_W     = 12;
   localparam logic [RECIP_W-1:0] RECIP3 = 12'd2731;
   localparam logic [RECIP_W-1:0] RECIP5 = 12'd1639;
   localparam logic [RECIP_W-1:0] RECIP8 = 12'd1024;

   // result queue and pipeline
   localparam int FIFO_DEPTH  = 8;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = FIFO_PTR_W + 1;
   localparam int PIPE_STAGES = 4;            // accept to queue push

   typedef struct packed {
      logic [WID_W-1:0] width;
      logic [ROW_W-1:0] height;
      logic             filter_enable;
      logic             restart;
   } cfg_type;

   // border flags of the pixel that leaves the window centre
   typedef struct packed {
      logic emit;
      logic up;
      logic dn;
      logic lf;
      logic rt;
      logic last;
   } pos_type;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      div_sel_type      div_sel;
      logic [PIX_W-1:0] centre;
      logic             last;
   } sum_type;

   typedef struct packed {
      logic [PIX_W-1:0] coverage;
      logic [PIX_W-1:0] alpha;
      logic             frame_last;
   } result_type;

endpackage

### rtl/core/naf_stream_if.sv
// ----------------------------------------------------------------------------
// naf_stream_if
// Valid/ready channels for pixel requests and filter results.
// ----------------------------------------------------------------------------
interface naf_req_if import naf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_value;
   logic             is_filler;

   modport source (output valid, output pixel_value, output is_filler, input ready);
   modport sink   (input valid, input pixel_value, input is_filler, output ready);
endinterface

interface naf_rsp_if import naf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] coverage;
   logic [PIX_W-1:0] alpha;
   logic             frame_last;

   modport source (output valid, output coverage, output alpha, output frame_last,
                   input ready);
   modport sink   (input valid, input coverage, input alpha, input frame_last,
                   output ready);
endinterface

### rtl/core/naf_ram.sv
// ----------------------------------------------------------------------------
// naf_ram
// Generic single-clock RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module naf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/naf_csr.sv
// ----------------------------------------------------------------------------
// naf_csr
// APB register file: image width, image height, filter enable. Produces the
// clamped geometry and a restart pulse on geometry writes.
// ----------------------------------------------------------------------------
module naf_csr import naf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [WREG_W-1:0] width_ff, width_in;
   logic [HREG_W-1:0] height_ff, height_in;
   logic              enable_ff, enable_in;
   logic              wr_stb;
   logic              restart;
   reg_index_type     index;

   assign pready = 1'b1;
   assign wr_stb = psel & penable & pwrite;
   assign index  = paddr[3:2];

   // register writes
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      enable_in = enable_ff;
      restart   = 1'b0;
      if (wr_stb) begin
         unique case (index)
            REG_IMAGE_WIDTH: begin
               width_in = pwdata[WREG_W-1:0];
               restart  = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               height_in = pwdata[HREG_W-1:0];
               restart   = 1'b1;
            end
            REG_FILTER_ENABLE: enable_in = pwdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         enable_ff <= RST_FILTER_EN;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         enable_ff <= enable_in;
      end
   end

   // read back
   always_comb begin
      unique case (index)
         REG_IMAGE_WIDTH:   prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT:  prdata = CSR_DATA_W'(height_ff);
         REG_FILTER_ENABLE: prdata = CSR_DATA_W'(enable_ff);
         default:           prdata = '0;
      endcase
   end

   // clamp geometry into the supported range
   always_comb begin
      if (width_ff < WREG_W'(2)) begin
         cfg.width = WID_W'(2);
      end else if (width_ff > WREG_W'(MAX_WIDTH)) begin
         cfg.width = WID_W'(MAX_WIDTH);
      end else begin
         cfg.width = WID_W'(width_ff);
      end
      if (height_ff < HREG_W'(2)) begin
         cfg.height = ROW_W'(2);
      end else if (height_ff > HREG_W'(MAX_HEIGHT)) begin
         cfg.height = ROW_W'(MAX_HEIGHT);
      end else begin
         cfg.height = ROW_W'(height_ff);
      end
      cfg.filter_enable = enable_ff;
      cfg.restart       = restart;
   end

endmodule

### rtl/core/naf_window.sv
// ----------------------------------------------------------------------------
// naf_window
// Line store read-modify-write, 3x3 window shift and masked neighbour sum.
// Stage B: line data back from RAM, write back, shift window.
// Stage C: sum the in-image neighbours, pick the divisor.
// ----------------------------------------------------------------------------
module naf_window import naf_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [COL_W-1:0] rd_addr,
   input  logic [PIX_W-1:0] pixel,
   input  pos_type          pos,
   output logic             sum_valid,
   output sum_type          sum_data
);

   // stage B
   logic             b_valid_ff, b_valid_in;
   logic [COL_W-1:0] b_addr_ff;
   logic [PIX_W-1:0] b_pixel_ff;
   pos_type          b_pos_ff;
   logic             fwd_hit_ff, fwd_hit_in;
   logic [LINE_W-1:0] fwd_data_ff;
   logic [LINE_W-1:0] rd_line, line, wr_line;
   logic [PIX_W-1:0] top, mid;
   logic [PIX_W-1:0] win_ff [9];
   logic [PIX_W-1:0] win_in [9];

   // stage C
   logic             c_valid_ff, c_valid_in;
   pos_type          c_pos_ff;
   logic [SUM_W-1:0] sum;
   div_sel_type      div_sel;

   // stage S (output)
   logic             s_valid_ff, s_valid_in;
   sum_type          s_data_ff;

   // line stores packed as {upper, middle}, both indexed by column
   naf_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_addr_ff),
      .wr_data (wr_line),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_line)
   );

   // forward a write that races the read of the same column
   assign line    = fwd_hit_ff ? fwd_data_ff : rd_line;
   assign top     = line[LINE_W-1:PIX_W];
   assign mid     = line[PIX_W-1:0];
   assign wr_line = {mid, b_pixel_ff};
   assign fwd_hit_in = accept & b_valid_ff & (rd_addr == b_addr_ff);
   assign b_valid_in = accept;

   always_ff @(posedge clock) begin
      b_addr_ff   <= rd_addr;
      b_pixel_ff  <= pixel;
      b_pos_ff    <= pos;
      fwd_data_ff <= wr_line;
      c_pos_ff    <= b_pos_ff;
      s_data_ff   <= '{sum: sum, div_sel: div_sel, centre: win_ff[4], last: c_pos_ff.last};
   end

   // window shift: columns move left, new column enters on the right
   always_comb begin
      for (int k = 0; k < 9; k++) begin
         win_in[k] = win_ff[k];
      end
      if (b_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_in[k*3]     = win_ff[k*3 + 1];
            win_in[k*3 + 1] = win_ff[k*3 + 2];
         end
         win_in[2] = top;
         win_in[5] = mid;
         win_in[8] = b_pixel_ff;
      end
   end

   assign c_valid_in = b_valid_ff & b_pos_ff.emit;
   assign s_valid_in = c_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         b_valid_ff <= b_valid_in;
         fwd_hit_ff <= fwd_hit_in;
         c_valid_ff <= c_valid_in;
         s_valid_ff <= s_valid_in;
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   // neighbour sum over the in-image positions
   always_comb begin
      sum = '0;
      if (c_pos_ff.lf) begin
         sum = sum + SUM_W'(win_ff[3]);
         if (c_pos_ff.up) sum = sum + SUM_W'(win_ff[0]);
         if (c_pos_ff.dn) sum = sum + SUM_W'(win_ff[6]);
      end
      if (c_pos_ff.rt) begin
         sum = sum + SUM_W'(win_ff[5]);
         if (c_pos_ff.up) sum = sum + SUM_W'(win_ff[2]);
         if (c_pos_ff.dn) sum = sum + SUM_W'(win_ff[8]);
      end
      if (c_pos_ff.up) sum = sum + SUM_W'(win_ff[1]);
      if (c_pos_ff.dn) sum = sum + SUM_W'(win_ff[7]);
   end

   // neighbour count: 8 inside, 5 on an edge, 3 at a corner
   always_comb begin
      if ((c_pos_ff.up & c_pos_ff.dn) && (c_pos_ff.lf & c_pos_ff.rt)) begin
         div_sel = DIV_BY8;
      end else if ((c_pos_ff.up & c_pos_ff.dn) || (c_pos_ff.lf & c_pos_ff.rt)) begin
         div_sel = DIV_BY5;
      end else begin
         div_sel = DIV_BY3;
      end
   end

   assign sum_valid = s_valid_ff;
   assign sum_data  = s_data_ff;

   // forwarded data only ever belongs to a request now in stage B
   a_fwd_with_item: assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> b_valid_ff)
      else $error("line store forward without a request in stage B");

endmodule

### rtl/core/naf_arith.sv
// ----------------------------------------------------------------------------
// naf_arith
// Divides the neighbour sum by its count (reciprocal multiply), adds the
// centre pixel, saturates and forms coverage (filter off: centre passes).
// ----------------------------------------------------------------------------
module naf_arith import naf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       sum_valid,
   input  sum_type    sum_data,
   input  logic       filter_enable,
   output logic       push,
   output result_type push_data
);

   logic [RECIP_W-1:0]       recip;
   logic [SUM_W+RECIP_W-1:0] product;
   logic                     m_valid_ff, m_valid_in;
   logic [PIX_W-1:0]         m_quot_ff;
   logic [PIX_W-1:0]         m_centre_ff;
   logic                     m_last_ff;
   logic [PIX_W:0]           total;
   logic [PIX_W-1:0]         alpha;

   // reciprocal of the neighbour count
   always_comb begin
      case (sum_data.div_sel)
         DIV_BY3: recip = RECIP3;
         DIV_BY5: recip = RECIP5;
         default: recip = RECIP8;
      endcase
   end

   assign product    = (SUM_W+RECIP_W)'(sum_data.sum) * (SUM_W+RECIP_W)'(recip);
   assign m_valid_in = sum_valid;

   always_ff @(posedge clock) begin
      m_quot_ff   <= product[RECIP_SHIFT +: PIX_W];
      m_centre_ff <= sum_data.centre;
      m_last_ff   <= sum_data.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= m_valid_in;
      end
   end

   // centre plus mean, clipped at full scale
   assign total = {1'b0, m_centre_ff} + {1'b0, m_quot_ff};
   assign alpha = total[PIX_W] ? PIX_MAX : total[PIX_W-1:0];

   always_comb begin
      push                 = m_valid_ff;
      push_data.frame_last = m_last_ff;
      if (filter_enable) begin
         push_data.alpha    = alpha;
         push_data.coverage = (alpha != '0) ? PIX_MAX : '0;
      end else begin
         push_data.alpha    = m_centre_ff;
         push_data.coverage = m_centre_ff;
      end
   end

endmodule

### rtl/core/naf_out_fifo.sv
// ----------------------------------------------------------------------------
// naf_out_fifo
// Result queue between the fixed-latency pipeline and the result channel.
// ----------------------------------------------------------------------------
module naf_out_fifo import naf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  result_type            push_data,
   input  logic                  pop,
   output logic                  not_empty,
   output result_type            head_data,
   output logic [FIFO_CNT_W-1:0] count
);

   result_type              entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   head_ff, head_in;
   logic [FIFO_PTR_W-1:0]   tail_ff, tail_in;
   logic [FIFO_CNT_W-1:0]   count_ff, count_in;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[tail_ff] <= push_data;
      end
   end

   // pointers and fill level
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = tail_ff + FIFO_PTR_W'(1);
      end
      if (pop) begin
         head_in = head_ff + FIFO_PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + FIFO_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - FIFO_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head_data = entry_ff[head_ff];
   assign count     = count_ff;

   // credit scheme upstream must keep the queue from overflowing
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (count_ff < FIFO_CNT_W'(FIFO_DEPTH)))
      else $error("result queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("result queue popped while empty");

endmodule

### rtl/core/neighbourhood_antialias_filter_core.sv
// ----------------------------------------------------------------------------
// neighbourhood_antialias_filter_core
// 3x3 neighbourhood mean filter with edge clamp on a raster grey stream.
//
// Requests carry one pixel (or a filler) in raster order on req_stream; each
// request is taken at a clock edge with valid and ready high. Results leave
// on rsp_stream under the same handshake: alpha = centre + mean of the
// in-image 8-neighbours (saturated), coverage = 255 when alpha is nonzero,
// frame_last on the frame's final pixel. With filtering off both equal the
// pixel. The result of a pixel is caused by the request width+1 positions
// later, so the last row is drained with width+1 fillers.
// One request per clock is taken while ready is high; the result of a request
// is offered once it has passed the line RAM read, window, sum, multiply and
// queue write.
// ready depends only on the 8-entry result queue plus results in flight, so
// a stalled receiver lets up to 8 results collect before requests back off.
// Reset (synchronous) clears counters, window and queue; line stores are not
// cleared and need no clearing pass. The user writes registers over APB only
// while the block is idle (not enforced); a geometry write starts a new frame.
// ----------------------------------------------------------------------------
module neighbourhood_antialias_filter_core import naf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   naf_req_if.sink               req_stream,
   naf_rsp_if.source             rsp_stream,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type                 cfg;
   logic                    accept;
   logic [PIX_W-1:0]        pixel;
   logic [COL_W-1:0]        col_ff, col_in;
   logic [ROW_W-1:0]        row_ff, row_in;
   logic [WID_W-1:0]        col_wide, col_inc, ocol, w_last;
   logic [ROW_W-1:0]        orow, h_last;
   logic                    emit_raw;
   logic                    wrap;
   pos_type                 pos;
   logic [PIPE_STAGES-1:0]  inflight_ff, inflight_in;
   logic [FIFO_CNT_W:0]     credit;
   logic                    sum_valid;
   sum_type                 sum_data;
   logic                    push;
   result_type              push_data;
   logic                    fifo_not_empty;
   result_type              head_data;
   logic [FIFO_CNT_W-1:0]   fifo_count;

   naf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // request handshake; fillers count as zero pixels
   assign accept = req_stream.valid & req_stream.ready;
   assign pixel  = req_stream.is_filler ? '0 : req_stream.pixel_value;

   // position of the pixel leaving the window centre, and its borders
   always_comb begin
      col_wide = {1'b0, col_ff};
      col_inc  = col_wide + WID_W'(1);
      wrap     = (col_inc >= cfg.width);
      w_last   = cfg.width - WID_W'(1);
      h_last   = cfg.height - ROW_W'(1);
      if (col_ff != '0) begin
         emit_raw = (row_ff != '0);
         orow     = row_ff - ROW_W'(1);
         ocol     = col_wide - WID_W'(1);
      end else begin
         emit_raw = (row_ff >= ROW_W'(2));
         orow     = row_ff - ROW_W'(2);
         ocol     = w_last;
      end
      pos.emit = emit_raw && (orow < cfg.height) && (ocol < cfg.width);
      pos.up   = (orow != '0);
      pos.dn   = (orow < h_last);
      pos.lf   = (ocol != '0);
      pos.rt   = (ocol < w_last);
      pos.last = (orow == h_last) && (ocol == w_last);
   end

   // raster counters; frame restarts after its last result or a geometry write
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg.restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (pos.emit && pos.last) begin
            col_in = '0;
            row_in = '0;
         end else if (wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end
   end

   // results in flight toward the queue
   assign inflight_in = {inflight_ff[PIPE_STAGES-2:0], accept & pos.emit};

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         inflight_ff <= '0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         inflight_ff <= inflight_in;
      end
   end

   // queue space reserved for every result already in the pipeline
   always_comb begin
      credit = (FIFO_CNT_W+1)'(fifo_count);
      for (int k = 0; k < PIPE_STAGES; k++) begin
         credit = credit + (FIFO_CNT_W+1)'(inflight_ff[k]);
      end
   end

   assign req_stream.ready = (credit < (FIFO_CNT_W+1)'(FIFO_DEPTH));

   naf_window u_window (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rd_addr   (col_ff),
      .pixel     (pixel),
      .pos       (pos),
      .sum_valid (sum_valid),
      .sum_data  (sum_data)
   );

   naf_arith u_arith (
      .clock         (clock),
      .reset         (reset),
      .sum_valid     (sum_valid),
      .sum_data      (sum_data),
      .filter_enable (cfg.filter_enable),
      .push          (push),
      .push_data     (push_data)
   );

   naf_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_stream.valid & rsp_stream.ready),
      .not_empty (fifo_not_empty),
      .head_data (head_data),
      .count     (fifo_count)
   );

   assign rsp_stream.valid      = fifo_not_empty;
   assign rsp_stream.coverage   = head_data.coverage;
   assign rsp_stream.alpha      = head_data.alpha;
   assign rsp_stream.frame_last = head_data.frame_last;

   // the in-flight tracker must line up with the real pipeline output
   a_push_tracked: assert property (@(posedge clock) disable iff (reset)
      push == inflight_ff[PIPE_STAGES-1])
      else $error("queue push does not match in-flight tracker");

   // the frame's last pixel wraps the raster counters
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && pos.emit && pos.last) |=> (col_ff == '0) && (row_ff == '0))
      else $error("counters not cleared after end of frame");

   // the row counter never runs past the drain row
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      row_ff <= cfg.height + ROW_W'(1))
      else $error("row counter beyond frame");

endmodule
